>>> design/wrsi_pkg.sv
`default_nettype none

package wrsi_pkg;

    // Averages and sums are kept as 64-bit words that wrap.
    localparam int ACC_W = 64;

    // Period register and change counter.
    localparam int                PER_W        = 10;
    localparam logic [PER_W-1:0]  CNT_MAX      = 10'd1023;
    localparam logic [PER_W-1:0]  PERIOD_RESET = 10'd14;

    // Input item price field as it travels on the bus.
    localparam int PRICE_IN_W = 32;

    // Result format: percent in Q7.16.
    localparam int                RSI_W      = 23;
    localparam int                RSI_FRAC_W = 16;
    localparam int                RSI_SCALE  = 100;
    localparam int                SCALE_W    = 7;
    localparam logic [RSI_W-1:0]  RSI_FULL   = 23'd6553600;
    localparam logic [RSI_W-1:0]  RSI_HALF   = 23'd3276800;
    localparam int                DATA_OUT_W = 24;

    // Ratio numerator is the average gain * 100 * 2^16.
    localparam int SCL_W  = ACC_W + SCALE_W;
    localparam int NUM_W  = SCL_W + RSI_FRAC_W;
    localparam int STEP_W = $clog2(NUM_W + 1);

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

endpackage

`default_nettype wire

>>> design/wrsi_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend is loaded left
// aligned and only its top i_req.steps bits are consumed.
module wrsi_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire wrsi_pkg::t_div_req            i_req,
    input  wire logic [wrsi_pkg::NUM_W-1:0]    i_dividend,
    input  wire logic [wrsi_pkg::ACC_W-1:0]    i_divisor,
    output logic                               o_done,
    output logic [wrsi_pkg::ACC_W-1:0]         o_quotient
);
    import wrsi_pkg::*;

    logic [NUM_W-1:0]  r_num;
    logic [ACC_W-1:0]  r_div;
    logic [ACC_W-1:0]  r_rem;
    logic [ACC_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [ACC_W:0]    n_trial;
    logic [ACC_W:0]    n_diff;
    logic              n_fits;
    logic [ACC_W-1:0]  n_rem;

    // One trial subtraction of the divisor from the shifted remainder.
    always_comb begin
        n_trial = {r_rem, r_num[NUM_W-1]};
        n_diff  = n_trial - {1'b0, r_div};
        n_fits  = (n_trial >= {1'b0, r_div});
        n_rem   = n_fits ? n_diff[ACC_W-1:0] : n_trial[ACC_W-1:0];
    end

    // Step counter and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt  <= i_req.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand, remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= n_rem;
            r_quo <= {r_quo[ACC_W-2:0], n_fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> design/wilder_rsi_stream.sv
`default_nettype none

// A series-start item goes from acceptance straight to the finish state, an item inside
// the seed window passes through the step state first, and an item past it runs both
// average divisions and, unless the average loss or the sum is zero, the ratio division.
// Each may then wait for the output register. One item at a time: input waits in idle
// while the shared bit-serial divider works (64 dividend bits per average, 87 for the ratio).
// Reset is synchronous and active low: period returns to 14 and the price history clears.
module wilder_rsi_stream #(
    parameter int PRICE_WIDTH         = 32,
    parameter int EXTRA_FRACTION_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration: period register.
    input  wire logic                                i_cfg_period_we,
    input  wire logic [wrsi_pkg::PER_W-1:0]          i_cfg_period,
    // Input items.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [wrsi_pkg::PRICE_IN_W-1:0]     s_axis_tdata,  // [31:0] price
    input  wire logic                                s_axis_tuser,  // [0] series_start
    // Result items.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [wrsi_pkg::DATA_OUT_W-1:0]          m_axis_tdata,  // [22:0] rsi, [23] zero
    output logic                                     m_axis_tuser   // [0] rsi_valid
);
    import wrsi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,
        S_PREP,
        S_DSTART,
        S_DWAIT,
        S_RSI,
        S_RCHK,
        S_RWAIT,
        S_FINISH
    } t_state;

    t_state                 r_state;
    logic [PER_W-1:0]       r_period;
    logic [PRICE_WIDTH-1:0] r_prev;
    logic [PER_W-1:0]       r_cnt;
    logic [ACC_W-1:0]       r_g;
    logic [ACC_W-1:0]       r_l;
    logic                   r_has;
    logic                   r_seeded;
    logic                   r_smooth;
    logic                   r_side;
    logic [ACC_W-1:0]       r_gain;
    logic [ACC_W-1:0]       r_loss;
    logic [ACC_W-1:0]       r_num;
    logic [ACC_W-1:0]       r_sum;
    logic [SCL_W-1:0]       r_scaled;
    logic [RSI_W-1:0]       r_res;
    logic                   r_res_valid;
    logic [RSI_W-1:0]       r_out_rsi;
    logic                   r_out_user;
    logic                   r_out_tvalid;

    logic [PER_W-1:0]       n_per;
    logic [PER_W-1:0]       n_pm1;
    logic [PRICE_WIDTH-1:0] n_price;
    logic [ACC_W-1:0]       n_gain;
    logic [ACC_W-1:0]       n_loss;
    logic [PER_W-1:0]       n_cnt_inc;
    logic [ACC_W-1:0]       n_sel_acc;
    logic [ACC_W-1:0]       n_sel_inc;
    logic [ACC_W-1:0]       n_mac;

    t_div_req               div_req;
    logic [NUM_W-1:0]       div_dividend;
    logic [ACC_W-1:0]       div_divisor;
    logic                   div_done;
    logic [ACC_W-1:0]       div_quotient;

    // Effective period, price change and counter update.
    always_comb begin
        n_per     = (r_period == '0) ? PER_W'(1) : r_period;
        n_pm1     = n_per - 1'b1;
        n_price   = PRICE_WIDTH'(s_axis_tdata);
        n_gain    = '0;
        n_loss    = '0;
        if (n_price > r_prev) begin
            n_gain = ACC_W'(n_price - r_prev) << EXTRA_FRACTION_BITS;
        end
        if (n_price < r_prev) begin
            n_loss = ACC_W'(r_prev - n_price) << EXTRA_FRACTION_BITS;
        end
        n_cnt_inc = (r_cnt < CNT_MAX) ? (r_cnt + 1'b1) : r_cnt;
    end

    // Smoothing numerator avg*(period-1)+new for the side being worked on.
    always_comb begin
        n_sel_acc = r_side ? r_l : r_g;
        n_sel_inc = r_side ? r_loss : r_gain;
        n_mac     = n_sel_acc * ACC_W'(n_pm1) + n_sel_inc;
    end

    // Divider operands: averages divide by the period, the ratio by the sum.
    always_comb begin
        div_req.start = (r_state == S_DSTART) || ((r_state == S_RCHK) && (r_sum != '0));
        if (r_state == S_DSTART) begin
            div_req.steps = STEP_W'(ACC_W);
            div_dividend  = {r_num, {(NUM_W-ACC_W){1'b0}}};
            div_divisor   = ACC_W'(n_per);
        end else begin
            div_req.steps = STEP_W'(NUM_W);
            div_dividend  = {r_scaled, {RSI_FRAC_W{1'b0}}};
            div_divisor   = r_sum;
        end
    end

    wrsi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // Sequencer, series state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_period     <= PERIOD_RESET;
            r_cnt        <= '0;
            r_has        <= 1'b0;
            r_seeded     <= 1'b0;
            r_out_tvalid <= 1'b0;
        end else begin
            if (i_cfg_period_we) begin
                r_period <= i_cfg_period;
            end
            // The finish state reloads the output register itself.
            if (r_out_tvalid && m_axis_tready && (r_state != S_FINISH)) begin
                r_out_tvalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_prev <= n_price;
                        if (s_axis_tuser || !r_has) begin
                            r_cnt       <= '0;
                            r_g         <= '0;
                            r_l         <= '0;
                            r_has       <= 1'b1;
                            r_seeded    <= 1'b0;
                            r_res       <= '0;
                            r_res_valid <= 1'b0;
                            r_state     <= S_FINISH;
                        end else begin
                            r_gain  <= n_gain;
                            r_loss  <= n_loss;
                            r_cnt   <= n_cnt_inc;
                            r_state <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    r_side <= 1'b0;
                    if (r_seeded) begin
                        r_smooth <= 1'b1;
                        r_state  <= S_PREP;
                    end else begin
                        r_g      <= r_g + r_gain;
                        r_l      <= r_l + r_loss;
                        r_smooth <= 1'b0;
                        if (r_cnt >= n_per) begin
                            r_seeded <= 1'b1;
                            r_state  <= S_PREP;
                        end else begin
                            r_res       <= '0;
                            r_res_valid <= 1'b0;
                            r_state     <= S_FINISH;
                        end
                    end
                end
                S_PREP: begin
                    r_num   <= r_smooth ? n_mac : n_sel_acc;
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_done) begin
                        if (r_side) begin
                            r_l     <= div_quotient;
                            r_state <= S_RSI;
                        end else begin
                            r_g     <= div_quotient;
                            r_side  <= 1'b1;
                            r_state <= S_PREP;
                        end
                    end
                end
                S_RSI: begin
                    // Zero average loss is settled without a division.
                    if (r_l == '0) begin
                        r_res       <= (r_g != '0) ? RSI_FULL : RSI_HALF;
                        r_res_valid <= 1'b1;
                        r_state     <= S_FINISH;
                    end else begin
                        r_sum    <= r_g + r_l;
                        r_scaled <= SCL_W'(r_g) * SCL_W'(RSI_SCALE);
                        r_state  <= S_RCHK;
                    end
                end
                S_RCHK: begin
                    // A sum that wraps to zero gives zero.
                    if (r_sum == '0) begin
                        r_res       <= '0;
                        r_res_valid <= 1'b1;
                        r_state     <= S_FINISH;
                    end else begin
                        r_state <= S_RWAIT;
                    end
                end
                S_RWAIT: begin
                    if (div_done) begin
                        r_res       <= div_quotient[RSI_W-1:0];
                        r_res_valid <= 1'b1;
                        r_state     <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_out_tvalid || m_axis_tready) begin
                        r_out_rsi    <= r_res;
                        r_out_user   <= r_res_valid;
                        r_out_tvalid <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_tvalid;
    assign m_axis_tdata  = {{(DATA_OUT_W-RSI_W){1'b0}}, r_out_rsi};
    assign m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

>>> dv/wilder_rsi_stream_tb.sv
module wilder_rsi_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wrsi_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int STALL_LIMIT    = 20000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_PHASES  = 8;
    localparam int ITEMS_PER_PHASE = 56;

    // One result item: rsi in Q7.16 percent and its valid flag.
    typedef struct packed {
        logic [RSI_W-1:0] rsi;
        logic             valid;
    } t_rsi_result;

    // One row of the directed stimulus, with an optional period write before it.
    typedef struct {
        bit               cfg_write;
        logic [PER_W-1:0] cfg_value;
        logic [31:0]      price;
        logic             series_start;
        bit               typed;
        t_rsi_result      typed_result;
    } t_stim_row;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;
    typedef enum int {STYLE_WILD, STYLE_WALK, STYLE_FLAT, STYLE_RISE, STYLE_FALL} t_price_style;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_period_we = 1'b0;
    logic [PER_W-1:0]        i_cfg_period = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [PRICE_IN_W-1:0]   s_axis_tdata = '0;
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [DATA_OUT_W-1:0]   m_axis_tdata;
    logic                    m_axis_tuser;

    // Predictor state: period register and series history.
    logic [PER_W-1:0] period_reg = PERIOD_RESET;
    logic [31:0]      last_price = '0;
    logic [PER_W-1:0] change_count = '0;
    logic [63:0]      mean_up = '0;
    logic [63:0]      mean_down = '0;
    bit               price_held = 1'b0;
    bit               averages_seeded = 1'b0;

    t_rsi_result pending_rsi[$];
    t_stim_row   directed_rows [DIRECTED_ROWS];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int valid_results = 0;
    int period_writes = 0;
    int quiet_cycles = 0;

    wilder_rsi_stream u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_period_we (i_cfg_period_we),
        .i_cfg_period    (i_cfg_period),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Wilder RSI for one accepted price; updates the series history.
    task automatic compute_wilder_rsi(input logic [31:0] price, input logic series_start,
                                      output t_rsi_result result);
        logic [63:0]  per;
        logic [63:0]  up;
        logic [63:0]  down;
        logic [63:0]  total;
        logic [127:0] ratio;
        per = (period_reg == '0) ? 64'd1 : {54'd0, period_reg};
        result = '0;
        if (series_start || !price_held) begin
            last_price = price;
            change_count = '0;
            mean_up = '0;
            mean_down = '0;
            price_held = 1'b1;
            averages_seeded = 1'b0;
            return;
        end
        up = (price > last_price) ? {32'd0, price - last_price} : 64'd0;
        down = (price < last_price) ? {32'd0, last_price - price} : 64'd0;
        up = up << 16;
        down = down << 16;
        last_price = price;
        if (change_count < CNT_MAX) begin
            change_count = change_count + 1'b1;
        end
        if (!averages_seeded) begin
            // Seed window: sum the changes, then divide once the window is full.
            mean_up = mean_up + up;
            mean_down = mean_down + down;
            if ({54'd0, change_count} >= per) begin
                mean_up = mean_up / per;
                mean_down = mean_down / per;
                averages_seeded = 1'b1;
            end
        end else begin
            mean_up = (mean_up * (per - 64'd1) + up) / per;
            mean_down = (mean_down * (per - 64'd1) + down) / per;
        end
        if (averages_seeded) begin
            // With no average loss the index pins to 100, or to 50 when flat.
            if (mean_down == 64'd0) begin
                result.rsi = (mean_up != 64'd0) ? RSI_FULL : RSI_HALF;
            end else begin
                total = mean_up + mean_down;
                if (total == 64'd0) begin
                    result.rsi = '0;
                end else begin
                    ratio = ({64'd0, mean_up} * 128'd6553600) / {64'd0, total};
                    result.rsi = ratio[RSI_W-1:0];
                end
            end
            result.valid = 1'b1;
        end
    endtask

    function automatic t_stim_row make_row(input bit cfg_write, input int cfg_value,
                                           input logic [31:0] price, input logic series_start,
                                           input bit typed, input logic [RSI_W-1:0] rsi,
                                           input logic valid);
        t_stim_row row;
        row.cfg_write = cfg_write;
        row.cfg_value = cfg_value[PER_W-1:0];
        row.price = price;
        row.series_start = series_start;
        row.typed = typed;
        row.typed_result.rsi = rsi;
        row.typed_result.valid = valid;
        return row;
    endfunction

    // Offers one item, starting at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [31:0] price, input logic series_start,
                             input bit typed, input t_rsi_result typed_result);
        t_rsi_result predicted;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 260)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= price;
        s_axis_tuser <= series_start;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        compute_wilder_rsi(price, series_start, predicted);
        pending_rsi.insert(pending_rsi.size(), typed ? typed_result : predicted);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Holds the input side until every outstanding result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_rsi.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_period(input logic [PER_W-1:0] value);
        drain_results();
        i_cfg_period_we <= 1'b1;
        i_cfg_period <= value;
        period_reg = value;
        period_writes++;
        @(negedge i_clk);
        i_cfg_period_we <= 1'b0;
    endtask

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SEND: begin
                send_idle_pct = 71;
                recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_idle_pct = 0;
                recv_stall_pct = 71;
            end
            default: begin
                send_idle_pct = 21;
                recv_stall_pct = 21;
            end
        endcase
    endtask

    // Receiver: random back-pressure, changed at the falling edge.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin : check_result
        t_rsi_result oldest;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_rsi.size() == 0) begin
                $error("result item with nothing expected: rsi %0d, rsi_valid %0d",
                       m_axis_tdata[RSI_W-1:0], m_axis_tuser);
                fail_count++;
            end else begin
                oldest = pending_rsi.pop_front();
                if (m_axis_tdata[RSI_W-1:0] !== oldest.rsi) begin
                    $error("rsi: expected %0d, actual %0d", oldest.rsi,
                           m_axis_tdata[RSI_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tuser !== oldest.valid) begin
                    $error("rsi_valid: expected %0d, actual %0d", oldest.valid, m_axis_tuser);
                    fail_count++;
                end
                results_checked++;
                if (m_axis_tuser === 1'b1) begin
                    valid_results++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [31:0]      price;
        logic             series_start;
        logic [31:0]      walk_price;
        t_price_style     style;
        int               span;
        logic [PER_W-1:0] phase_periods [RANDOM_PHASES];

        // Directed rows: typed expectations where the answer is obvious.
        directed_rows[0]  = make_row(1'b0, 0,    32'd0,         1'b0, 1'b1, '0,       1'b0);
        directed_rows[1]  = make_row(1'b0, 0,    32'hFFFF_FFFF, 1'b0, 1'b1, '0,       1'b0);
        directed_rows[2]  = make_row(1'b0, 0,    32'd0,         1'b1, 1'b1, '0,       1'b0);
        directed_rows[3]  = make_row(1'b1, 1,    32'd5,         1'b1, 1'b1, '0,       1'b0);
        directed_rows[4]  = make_row(1'b0, 0,    32'd5,         1'b0, 1'b1, RSI_HALF, 1'b1);
        directed_rows[5]  = make_row(1'b0, 0,    32'd10,        1'b0, 1'b1, RSI_FULL, 1'b1);
        directed_rows[6]  = make_row(1'b0, 0,    32'd0,         1'b0, 1'b1, '0,       1'b1);
        directed_rows[7]  = make_row(1'b0, 0,    32'hFFFF_FFFF, 1'b0, 1'b1, RSI_FULL, 1'b1);
        directed_rows[8]  = make_row(1'b0, 0,    32'd0,         1'b0, 1'b1, '0,       1'b1);
        directed_rows[9]  = make_row(1'b1, 0,    32'd100,       1'b1, 1'b1, '0,       1'b0);
        directed_rows[10] = make_row(1'b0, 0,    32'd200,       1'b0, 1'b1, RSI_FULL, 1'b1);
        directed_rows[11] = make_row(1'b0, 0,    32'd150,       1'b0, 1'b1, '0,       1'b1);
        directed_rows[12] = make_row(1'b1, 2,    32'd100,       1'b1, 1'b1, '0,       1'b0);
        directed_rows[13] = make_row(1'b0, 0,    32'd110,       1'b0, 1'b1, '0,       1'b0);
        directed_rows[14] = make_row(1'b0, 0,    32'd100,       1'b0, 1'b1, RSI_HALF, 1'b1);
        directed_rows[15] = make_row(1'b0, 0,    32'd120,       1'b0, 1'b0, '0,       1'b0);
        directed_rows[16] = make_row(1'b0, 0,    32'd90,        1'b0, 1'b0, '0,       1'b0);
        directed_rows[17] = make_row(1'b1, 1023, 32'd95,        1'b0, 1'b0, '0,       1'b0);
        directed_rows[18] = make_row(1'b0, 0,    32'd95,        1'b0, 1'b0, '0,       1'b0);
        directed_rows[19] = make_row(1'b1, 5,    32'h8000_0000, 1'b1, 1'b1, '0,       1'b0);
        directed_rows[20] = make_row(1'b0, 0,    32'h8000_3F10, 1'b0, 1'b1, '0,       1'b0);
        directed_rows[21] = make_row(1'b0, 0,    32'h7FFF_0001, 1'b0, 1'b1, '0,       1'b0);
        directed_rows[22] = make_row(1'b1, 2,    32'h8000_0400, 1'b0, 1'b0, '0,       1'b0);
        directed_rows[23] = make_row(1'b1, 3,    32'h8000_0405, 1'b0, 1'b0, '0,       1'b0);
        directed_rows[24] = make_row(1'b0, 0,    32'd7,         1'b1, 1'b1, '0,       1'b0);

        phase_periods[0] = 10'd1;
        phase_periods[1] = 10'd3;
        phase_periods[2] = PERIOD_RESET;
        phase_periods[3] = 10'd7;
        phase_periods[4] = 10'd0;
        phase_periods[5] = 10'd30;
        phase_periods[6] = 10'd2;
        phase_periods[7] = CNT_MAX;

        // Reset once, released at a falling edge.
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, a period write where the row asks for one.
        set_idle_mode(IDLE_NONE);
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].cfg_write) begin
                write_period(directed_rows[r].cfg_value);
            end
            send_item(directed_rows[r].price, directed_rows[r].series_start,
                      directed_rows[r].typed, directed_rows[r].typed_result);
        end

        // Random part: series of shaped price paths under each period and idle mode.
        walk_price = 32'd7;
        style = STYLE_WALK;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_period(phase_periods[p]);
            set_idle_mode(t_idle_mode'(p % 4));
            span = (phase_periods[p] > 60) ? 60 : int'(phase_periods[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                series_start = ($urandom_range(0, 2 * span + 6) == 0);
                if (series_start) begin
                    style = t_price_style'($urandom_range(0, 4));
                end
                case (style)
                    STYLE_WILD: price = $urandom;
                    STYLE_WALK: price = walk_price + $urandom_range(0, 8191) - 32'd4096;
                    STYLE_FLAT: price = walk_price;
                    STYLE_RISE: price = walk_price + $urandom_range(0, 5000);
                    default:    price = walk_price - $urandom_range(0, 5000);
                endcase
                // Occasional stray price breaks up an otherwise smooth series.
                if ($urandom_range(0, 29) == 0) begin
                    price = $urandom;
                end
                send_item(price, series_start, 1'b0, '0);
                walk_price = price;
                // Now and then hold off until the block has emptied.
                if ($urandom_range(0, 59) == 0) begin
                    drain_results();
                end
            end
        end

        // Let the last results out, then watch for strays.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_rsi.size() != 0) begin
            $error("%0d expected results never arrived", pending_rsi.size());
            fail_count++;
        end

        $display("Sent %0d prices across %0d period writes, including 0, 1 and 1023.",
                 items_sent, period_writes);
        $display("Checked %0d results, %0d with a valid index, under four idle mixes.",
                 results_checked, valid_results);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> wilder_rsi_stream.f
design/wrsi_pkg.sv
design/wrsi_div.sv
design/wilder_rsi_stream.sv
dv/wilder_rsi_stream_tb.sv
